// ===== src/cfht_pkg.sv =====
// Shared types and constants for the coalesced feature hash table.
`timescale 1ns / 1ps
package cfht_pkg;

  localparam int PAYLOAD_W   = 13;
  localparam int NUMBERED_W  = 12;
  localparam int SIZE_LOG2_W = 4;
  localparam int CFG_W       = 12;

  localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_MAX   = 4'd12;
  localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = 4'd8;
  localparam logic [NUMBERED_W-1:0]  NUMBERED_RESET  = 12'd0;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_CLEAR  = 2'd0;
  localparam kind_t KIND_INSERT = 2'd1;
  localparam kind_t KIND_LOOKUP = 2'd2;
  localparam kind_t KIND_UNUSED = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_DUPLICATE = 2'd1;
  localparam status_t STATUS_NOT_FOUND = 2'd2;
  localparam status_t STATUS_FULL      = 2'd3;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SIZE_LOG2 = 1'd0;
  localparam cfg_idx_t CFG_NUMBERED  = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_LINK
  } state_t;

endpackage

// ===== src/cfht_slot_ram.sv =====
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cfht_slot_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/coalesced_feature_hash_table.sv =====
// Top level: sequencer of the coalesced-chaining hash table over one slot memory.
//
// Usage: an operation is taken when start is high and busy is low. in_kind selects
// clear, insert or lookup; the key is in_key_is_atom and in_key_value, and
// in_value_index is stored with the key on insert. Every operation gives exactly one
// beat on out_status and out_found_index, marked by out_valid for a single cycle;
// the receiver cannot hold it off, and busy is low again in that same cycle.
// Configuration (table size, numbered count) is written through cfg_we, cfg_index
// and cfg_wdata; the user writes it only while the block is idle (not enforced here).
// Steps, set by the single read port of the slot memory (one slot per access):
//   unused kind or numbered duplicate: answered from idle without walking the chain;
//   lookup / insert: one slot read per chain entry, then one slot read per free-slot
//     probe, then a write that links the new slot to the tail;
//   clear: all TABLE_DEPTH slots, one slot cleared per cycle.
// After reset the same clearing pass runs with busy high and
// gives no result beat; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
module coalesced_feature_hash_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic                              in_key_is_atom,
  input  logic [KEY_WIDTH-1:0]              in_key_value,
  input  logic [cfht_pkg::PAYLOAD_W-1:0]    in_value_index,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [cfht_pkg::PAYLOAD_W-1:0]    out_found_index,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [cfht_pkg::CFG_W-1:0]        cfg_wdata
);
  import cfht_pkg::*;

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW     = $clog2(TABLE_DEPTH + 1);
  localparam int LG_MAX = $clog2(TABLE_DEPTH + 1) - 1;
  localparam logic [IW-1:0] LINK_NONE = IW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic                 used;
    logic                 atom;
    logic [KEY_WIDTH-1:0] key;
    logic [PAYLOAD_W-1:0] payload;
    logic [IW-1:0]        link;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  state_t                 state_r, state_nxt;
  logic [SIZE_LOG2_W-1:0] size_log2_r;
  logic [NUMBERED_W-1:0]  numbered_r;
  kind_t                  kind_r, kind_nxt;
  logic                   atom_r, atom_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [PAYLOAD_W-1:0]   payload_r, payload_nxt;
  logic [AW-1:0]          p_r, p_nxt;
  logic [AW-1:0]          c_r, c_nxt;
  logic [IW-1:0]          cnt_r, cnt_nxt;
  slot_t                  tail_r, tail_nxt;
  logic                   clr_reply_r, clr_reply_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [PAYLOAD_W-1:0]   out_found_r, out_found_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  slot_t                  ram_wdata, rd;
  logic [SLOT_W-1:0]      ram_rdata;

  logic [SIZE_LOG2_W-1:0] lg_sat, lg_eff;
  logic [IW-1:0]          size_w;
  logic [AW-1:0]          mask;
  logic [KEY_WIDTH-1:0]   key_shr;
  logic [AW-1:0]          home;
  logic                   numbered_hit;
  logic                   rd_match;
  logic [IW-1:0]          scan_from;
  logic [AW-1:0]          scan_next;

  cfht_slot_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AW),
    .DATA_W (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = slot_t'(ram_rdata);

  // Size in use: saturate the log to 12, then to what the memory holds.
  assign lg_sat = (size_log2_r > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : size_log2_r;
  assign lg_eff = (lg_sat > SIZE_LOG2_W'(LG_MAX)) ? SIZE_LOG2_W'(LG_MAX) : lg_sat;
  assign size_w = IW'(1) << lg_eff;
  assign mask   = AW'(size_w - IW'(1));

  assign key_shr = in_key_value >> 3;
  assign home    = (in_key_is_atom ? key_shr[AW-1:0] : in_key_value[AW-1:0]) & mask;

  assign numbered_hit = !in_key_is_atom && !in_key_value[KEY_WIDTH-1] &&
                        (in_key_value != '0) &&
                        (in_key_value <= KEY_WIDTH'(numbered_r));

  assign rd_match = rd.used && (rd.atom == atom_r) && (rd.key == key_r);

  // The free-slot scan steps downward and wraps to the last slot in use.
  assign scan_from = (state_r == ST_WALK) ? IW'(p_r) : IW'(c_r);
  assign scan_next = ((scan_from == '0) || (scan_from > size_w)) ?
                     AW'(size_w - IW'(1)) : AW'(scan_from - IW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= SIZE_LOG2_RESET;
      numbered_r  <= NUMBERED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_LOG2: size_log2_r <= cfg_wdata[SIZE_LOG2_W-1:0];
        CFG_NUMBERED:  numbered_r  <= cfg_wdata[NUMBERED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    atom_r       <= atom_nxt;
    key_r        <= key_nxt;
    payload_r    <= payload_nxt;
    p_r          <= p_nxt;
    c_r          <= c_nxt;
    tail_r       <= tail_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    atom_nxt       = atom_r;
    key_nxt        = key_r;
    payload_nxt    = payload_r;
    p_nxt          = p_r;
    c_nxt          = c_r;
    cnt_nxt        = cnt_r;
    tail_nxt       = tail_r;
    clr_reply_nxt  = clr_reply_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    ram_we         = 1'b0;
    ram_waddr      = p_r;
    ram_raddr      = p_r;
    ram_wdata      = '{used: 1'b1, atom: atom_r, key: key_r, payload: payload_r,
                       link: LINK_NONE};

    unique case (state_r)
      ST_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = cnt_r[AW-1:0];
        ram_wdata.used = 1'b0;
        cnt_nxt        = cnt_r + IW'(1);
        if (cnt_r[AW-1:0] == LAST_SLOT) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = clr_reply_r;
          out_status_nxt = STATUS_OK;
          out_found_nxt  = '0;
        end
      end

      ST_IDLE: begin
        if (start) begin
          kind_nxt       = in_kind;
          atom_nxt       = in_key_is_atom;
          key_nxt        = in_key_value;
          payload_nxt    = in_value_index;
          p_nxt          = home;
          ram_raddr      = home;
          out_found_nxt  = '0;
          out_status_nxt = STATUS_OK;
          unique case (in_kind)
            KIND_CLEAR: begin
              cnt_nxt       = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            KIND_INSERT: begin
              if (numbered_hit) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STATUS_DUPLICATE;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            KIND_LOOKUP: state_nxt = ST_WALK;
            default:     out_valid_nxt = 1'b1;
          endcase
        end
      end

      ST_WALK: begin
        // Read data here belongs to slot p_r, issued in the previous cycle.
        if (!rd.used) begin
          // Only the home slot can be found empty.
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_INSERT) begin
            ram_we         = 1'b1;
            out_status_nxt = STATUS_OK;
          end else begin
            out_status_nxt = STATUS_NOT_FOUND;
          end
        end else if (rd_match) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_INSERT) begin
            out_status_nxt = STATUS_DUPLICATE;
          end else begin
            out_status_nxt = STATUS_OK;
            out_found_nxt  = rd.payload;
          end
        end else if (rd.link >= LINK_NONE) begin
          if (kind_r == KIND_INSERT) begin
            tail_nxt  = rd;
            c_nxt     = scan_next;
            ram_raddr = scan_next;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_NOT_FOUND;
          end
        end else begin
          p_nxt     = rd.link[AW-1:0];
          ram_raddr = rd.link[AW-1:0];
        end
      end

      ST_SCAN: begin
        ram_raddr = c_r;
        if (!rd.used) begin
          ram_we    = 1'b1;
          ram_waddr = c_r;
          state_nxt = ST_LINK;
        end else if ((cnt_r + IW'(1)) == size_w) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_FULL;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          c_nxt     = scan_next;
          ram_raddr = scan_next;
        end
      end

      ST_LINK: begin
        ram_we         = 1'b1;
        ram_waddr      = p_r;
        ram_wdata      = tail_r;
        ram_wdata.link = IW'(c_r);
        state_nxt      = ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_OK;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;

endmodule

// ===== src/cfht_checker.sv =====
// Port-level checks for the hash table, bound to the top level.
`timescale 1ns / 1ps
module cfht_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [1:0]                     out_status,
  input logic [cfht_pkg::PAYLOAD_W-1:0] out_found_index
);
  import cfht_pkg::*;

  // An accepted beat either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted operation neither busy nor answered");

  // A result beat is only given as the block returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  // Only a successful lookup carries a non-zero index.
  a_index_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_found_index != '0)) |-> (out_status == STATUS_OK))
    else $error("index given with a failing status");

  // Leaving reset starts the clearing pass.
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (busy && !out_valid))
    else $error("no clearing pass after reset");

endmodule

bind coalesced_feature_hash_table cfht_checker u_cfht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_found_index (out_found_index)
);
